@@ src/dllt_pkg.sv @@
package dllt_pkg;

   // Fixed field widths
   localparam int CMD_W       = 4;
   localparam int CODE_W      = 31;
   localparam int CLASS_W     = 8;
   localparam int PRICE_W     = 24;
   localparam int STATUS_W    = 3;
   localparam int ITEM_CNT_W  = 5;
   localparam int MAX_RESULTS = 16;
   localparam int WALK_W      = $clog2(MAX_RESULTS + 1);
   localparam int CAPACITY_DEF = 16;
   localparam int QUEUE_DEPTH  = 2;

   // Command codes as they arrive on the request port
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT_AFTER  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT_BEFORE = 4'd3;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_POP_BACK      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_REMOVE_KEY    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SEARCH        = 4'd7;
   localparam logic [CMD_W-1:0] CMD_WALK_FWD      = 4'd8;
   localparam logic [CMD_W-1:0] CMD_WALK_BACK     = 4'd9;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADCODE  = 3'd4;

   typedef enum logic [3:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_INSERT_AFTER,
      OP_INSERT_BEFORE,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_REMOVE_KEY,
      OP_SEARCH,
      OP_WALK_FWD,
      OP_WALK_BACK,
      OP_NONE
   } op_type;

   // Classified command held in the queue between front and back
   typedef struct packed {
      op_type               op;
      logic [CODE_W-1:0]    ref_code;
      logic [CODE_W-1:0]    new_code;
      logic [CLASS_W-1:0]   new_class;
      logic [PRICE_W-1:0]   new_price;
   } cmd_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [CODE_W-1:0]     entry_code;
      logic [CLASS_W-1:0]    entry_class;
      logic [PRICE_W-1:0]    entry_price;
      logic [ITEM_CNT_W-1:0] item_count;
      logic                  last;
   } rsp_item_type;

endpackage

@@ src/dllt_fifo.sv @@
module dllt_fifo
   import dllt_pkg::*;
#(
   parameter type ITEM_TYPE = cmd_item_type,
   parameter int  DEPTH     = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  ITEM_TYPE wdata,
   input  logic     pop,
   output logic     empty,
   output ITEM_TYPE rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ITEM_TYPE             store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   // pointer wrap and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ src/dllt_front.sv @@
module dllt_front
   import dllt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [CODE_W-1:0]  req_ref_code,
   input  logic [CODE_W-1:0]  req_new_code,
   input  logic [CLASS_W-1:0] req_new_class,
   input  logic [PRICE_W-1:0] req_new_price,
   input  logic               q_pop,
   output logic               q_empty,
   output cmd_item_type       q_item
);

   cmd_item_type item;

   // classify the command code; unused codes become a no-op
   always_comb begin
      item.ref_code  = req_ref_code;
      item.new_code  = req_new_code;
      item.new_class = req_new_class;
      item.new_price = req_new_price;
      case (req_cmd)
         CMD_PUSH_FRONT:    item.op = OP_PUSH_FRONT;
         CMD_PUSH_BACK:     item.op = OP_PUSH_BACK;
         CMD_INSERT_AFTER:  item.op = OP_INSERT_AFTER;
         CMD_INSERT_BEFORE: item.op = OP_INSERT_BEFORE;
         CMD_POP_FRONT:     item.op = OP_POP_FRONT;
         CMD_POP_BACK:      item.op = OP_POP_BACK;
         CMD_REMOVE_KEY:    item.op = OP_REMOVE_KEY;
         CMD_SEARCH:        item.op = OP_SEARCH;
         CMD_WALK_FWD:      item.op = OP_WALK_FWD;
         CMD_WALK_BACK:     item.op = OP_WALK_BACK;
         default:           item.op = OP_NONE;
      endcase
   end

   dllt_fifo #(
      .ITEM_TYPE (cmd_item_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (item),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_item)
   );

endmodule

@@ src/dllt_back.sv @@
module dllt_back
   import dllt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   input  cmd_item_type cmd_item,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_item_type rsp_item
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LIMIT  = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
   localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_CHECK, S_FREE, S_LINK1, S_LINK2,
      S_UNLINK, S_WALK, S_WALKCHK, S_EMIT
   } state_type;

   function automatic logic is_slot(input logic [LINK_W-1:0] l);
      return l < LINK_W'(CAPACITY);
   endfunction

   // entry stores
   logic [CODE_W-1:0]  code_mem  [CAPACITY];
   logic [CLASS_W-1:0] class_mem [CAPACITY];
   logic [PRICE_W-1:0] price_mem [CAPACITY];
   logic [LINK_W-1:0]  prev_mem  [CAPACITY];
   logic [LINK_W-1:0]  next_mem  [CAPACITY];

   // registered read port, addressed by the cursor
   logic [CODE_W-1:0]  rd_code_ff;
   logic [CLASS_W-1:0] rd_class_ff;
   logic [PRICE_W-1:0] rd_price_ff;
   logic [LINK_W-1:0]  rd_prev_ff;
   logic [LINK_W-1:0]  rd_next_ff;
   logic               rd_valid_ff;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [CODE_W-1:0]  key_ff, key_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [CLASS_W-1:0] class_ff, class_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  at_ff, at_in;
   logic [LINK_W-1:0]  p_ff, p_in;
   logic [LINK_W-1:0]  q_ff, q_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [WALK_W-1:0]  walk_ff, walk_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               more_ff, more_in;
   rsp_item_type       res_ff, res_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;

   // write controls
   logic               data_we;
   logic               prev_we, next_we;
   logic [IDX_W-1:0]   prev_addr, next_addr;
   logic [LINK_W-1:0]  prev_data, next_data;

   logic               match;
   logic [LINK_W-1:0]  nx;
   logic               fin;
   logic [LINK_W-1:0]  slot_n;

   assign rsp_item = res_ff;
   assign slot_n   = {1'b0, scan_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      code_in  = code_ff;
      class_in = class_ff;
      price_in = price_ff;
      cur_in   = cur_ff;
      at_in    = at_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      scan_in  = scan_ff;
      walk_in  = walk_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      more_in  = more_ff;
      res_in   = res_ff;
      valid_in = valid_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      data_we  = 1'b0;
      prev_we  = 1'b0;
      next_we  = 1'b0;
      prev_addr = scan_ff;
      next_addr = scan_ff;
      prev_data = p_ff;
      next_data = q_ff;
      match = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK) ||
              (rd_valid_ff && (rd_code_ff == key_ff));
      nx  = (op_ff == OP_WALK_FWD) ? rd_next_ff : rd_prev_ff;
      fin = !is_slot(nx) || (({1'b0, walk_ff} + 1'b1) >= (WALK_W + 1)'(LIMIT));

      case (state_ff)
         // take a command and settle the cases that need no table access
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               op_in    = cmd_item.op;
               key_in   = cmd_item.ref_code;
               code_in  = cmd_item.new_code;
               class_in = cmd_item.new_class;
               price_in = cmd_item.new_price;
               scan_in  = '0;
               walk_in  = '0;
               more_in  = 1'b0;
               res_in   = '0;
               res_in.status     = ST_OK;
               res_in.item_count = ITEM_CNT_W'(count_ff);
               res_in.last       = 1'b1;
               state_in = S_EMIT;
               case (cmd_item.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_in.status = ST_FULL;
                     end else if (cmd_item.new_code == '0) begin
                        res_in.status = ST_BADCODE;
                     end else if (cmd_item.op == OP_PUSH_FRONT) begin
                        p_in     = NIL;
                        q_in     = head_ff;
                        state_in = S_FREE;
                     end else if (cmd_item.op == OP_PUSH_BACK) begin
                        p_in     = tail_ff;
                        q_in     = NIL;
                        state_in = S_FREE;
                     end else if (cmd_item.ref_code == '0 || !is_slot(head_ff)) begin
                        res_in.status = ST_NOTFOUND;
                     end else begin
                        cur_in   = head_ff;
                        state_in = S_FIND;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_KEY, OP_SEARCH,
                  OP_WALK_FWD, OP_WALK_BACK: begin
                     if (count_ff == '0 || !is_slot(head_ff)) begin
                        res_in.status = ST_EMPTY;
                     end else if (cmd_item.op == OP_POP_BACK) begin
                        cur_in   = tail_ff;
                        state_in = S_FIND;
                     end else if (cmd_item.op == OP_POP_FRONT) begin
                        cur_in   = head_ff;
                        state_in = S_FIND;
                     end else if (cmd_item.op == OP_WALK_FWD) begin
                        cur_in   = head_ff;
                        state_in = S_WALK;
                     end else if (cmd_item.op == OP_WALK_BACK) begin
                        cur_in   = tail_ff;
                        state_in = S_WALK;
                     end else if (cmd_item.ref_code == '0) begin
                        res_in.status = ST_NOTFOUND;
                     end else begin
                        cur_in   = head_ff;
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // read issued at the cursor; data ready next cycle
         S_FIND: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (match) begin
               at_in = cur_ff;
               case (op_ff)
                  OP_INSERT_AFTER: begin
                     p_in     = cur_ff;
                     q_in     = rd_next_ff;
                     state_in = S_FREE;
                  end
                  OP_INSERT_BEFORE: begin
                     p_in     = rd_prev_ff;
                     q_in     = cur_ff;
                     state_in = S_FREE;
                  end
                  OP_SEARCH: begin
                     res_in.entry_code  = rd_code_ff;
                     res_in.entry_class = rd_class_ff;
                     res_in.entry_price = rd_price_ff;
                     state_in = S_EMIT;
                  end
                  default: begin
                     p_in     = rd_prev_ff;
                     q_in     = rd_next_ff;
                     state_in = S_UNLINK;
                  end
               endcase
            end else if (is_slot(rd_next_ff)) begin
               cur_in   = rd_next_ff;
               state_in = S_FIND;
            end else begin
               res_in.status = ST_NOTFOUND;
               state_in = S_EMIT;
            end
         end
         // lowest free slot, one valid bit a cycle
         S_FREE: begin
            if (!valid_ff[scan_ff]) begin
               state_in = S_LINK1;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         // fill the new entry and its own links
         S_LINK1: begin
            data_we   = 1'b1;
            prev_we   = 1'b1;
            next_we   = 1'b1;
            prev_data = p_ff;
            next_data = q_ff;
            valid_in[scan_ff] = 1'b1;
            state_in  = S_LINK2;
         end
         // hook the neighbours onto the new entry
         S_LINK2: begin
            if (is_slot(p_ff)) begin
               next_we   = 1'b1;
               next_addr = p_ff[IDX_W-1:0];
               next_data = slot_n;
            end else begin
               head_in = slot_n;
            end
            if (is_slot(q_ff)) begin
               prev_we   = 1'b1;
               prev_addr = q_ff[IDX_W-1:0];
               prev_data = slot_n;
            end else begin
               tail_in = slot_n;
            end
            count_in = count_ff + 1'b1;
            res_in.item_count = ITEM_CNT_W'(count_ff + 1'b1);
            state_in = S_EMIT;
         end
         // bridge the neighbours and free the slot
         S_UNLINK: begin
            if (is_slot(q_ff)) begin
               prev_we   = 1'b1;
               prev_addr = q_ff[IDX_W-1:0];
               prev_data = p_ff;
            end else begin
               tail_in = p_ff;
            end
            if (is_slot(p_ff)) begin
               next_we   = 1'b1;
               next_addr = p_ff[IDX_W-1:0];
               next_data = q_ff;
            end else begin
               head_in = q_ff;
            end
            valid_in[at_ff[IDX_W-1:0]] = 1'b0;
            count_in = count_ff - 1'b1;
            res_in.entry_code  = rd_code_ff;
            res_in.entry_class = rd_class_ff;
            res_in.entry_price = rd_price_ff;
            res_in.item_count  = ITEM_CNT_W'(count_ff - 1'b1);
            state_in = S_EMIT;
         end
         S_WALK: begin
            state_in = S_WALKCHK;
         end
         S_WALKCHK: begin
            res_in.entry_code  = rd_code_ff;
            res_in.entry_class = rd_class_ff;
            res_in.entry_price = rd_price_ff;
            res_in.last        = fin;
            more_in  = !fin;
            cur_in   = nx;
            walk_in  = walk_ff + 1'b1;
            state_in = S_EMIT;
         end
         // hand the result to the output queue
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = more_ff ? S_WALK : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         count_ff <= '0;
         more_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         more_ff  <= more_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      code_ff  <= code_in;
      class_ff <= class_in;
      price_ff <= price_in;
      cur_ff   <= cur_in;
      at_ff    <= at_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      scan_ff  <= scan_in;
      walk_ff  <= walk_in;
      res_ff   <= res_in;
   end

   // entry data stores
   always_ff @(posedge clock) begin
      if (data_we) begin
         code_mem[scan_ff]  <= code_ff;
         class_mem[scan_ff] <= class_ff;
         price_mem[scan_ff] <= price_ff;
      end
      rd_code_ff  <= code_mem[cur_ff[IDX_W-1:0]];
      rd_class_ff <= class_mem[cur_ff[IDX_W-1:0]];
      rd_price_ff <= price_mem[cur_ff[IDX_W-1:0]];
      rd_valid_ff <= valid_ff[cur_ff[IDX_W-1:0]];
   end

   // link stores
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_addr] <= prev_data;
      end
      rd_prev_ff <= prev_mem[cur_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_addr] <= next_data;
      end
      rd_next_ff <= next_mem[cur_ff[IDX_W-1:0]];
   end

endmodule

@@ src/doubly_linked_list_table.sv @@
// Channel  | Direction | Handshake            | Payload
// request  | in        | req_push / req_full  | cmd, ref_code, new_code, new_class, new_price
// response | out       | rsp_pop / rsp_empty  | status, entry fields, item_count, last
//
// One command at a time in the back engine; the front queue takes up to two more.
// Key lookup reads the table through a registered read port for each entry visited, the free
// slot scan tests one valid bit per slot, linking passes S_LINK1 and S_LINK2, and each result
// is handed over in S_EMIT; a walk passes S_WALK, S_WALKCHK and S_EMIT for each entry.
// Reset is synchronous and leaves the table empty.
// A full response queue holds the engine; the request queue fills meanwhile.
module doubly_linked_list_table
   import dllt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [CODE_W-1:0]     req_ref_code,
   input  logic [CODE_W-1:0]     req_new_code,
   input  logic [CLASS_W-1:0]    req_new_class,
   input  logic [PRICE_W-1:0]    req_new_price,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CODE_W-1:0]     rsp_entry_code_out,
   output logic [CLASS_W-1:0]    rsp_entry_class_out,
   output logic [PRICE_W-1:0]    rsp_entry_price_out,
   output logic [ITEM_CNT_W-1:0] rsp_item_count,
   output logic                  rsp_last
);

   cmd_item_type q_item;
   logic         q_pop, q_empty;
   rsp_item_type res_item, out_item;
   logic         res_push, res_full;

   dllt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_ref_code  (req_ref_code),
      .req_new_code  (req_new_code),
      .req_new_class (req_new_class),
      .req_new_price (req_new_price),
      .q_pop         (q_pop),
      .q_empty       (q_empty),
      .q_item        (q_item)
   );

   dllt_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .cmd_item  (q_item),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_item  (res_item)
   );

   dllt_fifo #(
      .ITEM_TYPE (rsp_item_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .wdata (res_item),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_item)
   );

   assign rsp_status          = out_item.status;
   assign rsp_entry_code_out  = out_item.entry_code;
   assign rsp_entry_class_out = out_item.entry_class;
   assign rsp_entry_price_out = out_item.entry_price;
   assign rsp_item_count      = out_item.item_count;
   assign rsp_last            = out_item.last;

   // a failed command always gives a single, closing result
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> rsp_last)
      else $error("failing result not marked last");

   // a failed command reports no entry
   a_fail_noentry: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |->
      (rsp_entry_code_out == '0 && rsp_entry_class_out == '0 && rsp_entry_price_out == '0))
      else $error("failing result carries entry data");

   // only defined status codes leave the block
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= ST_BADCODE))
      else $error("undefined status code");

   // reset flushes any pending results
   a_reset_flush: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results pending after reset");

endmodule

@@ sim/tb.sv @@
module tb;
   import dllt_pkg::*;

   localparam int CAP = 16;
   localparam logic [4:0] NIL = 5'd31;
   localparam int RANDOM_ITEMS = 460;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [CODE_W-1:0]     req_ref_code = '0;
   logic [CODE_W-1:0]     req_new_code = '0;
   logic [CLASS_W-1:0]    req_new_class = '0;
   logic [PRICE_W-1:0]    req_new_price = '0;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_empty;
   logic [STATUS_W-1:0]   rsp_status;
   logic [CODE_W-1:0]     rsp_entry_code_out;
   logic [CLASS_W-1:0]    rsp_entry_class_out;
   logic [PRICE_W-1:0]    rsp_entry_price_out;
   logic [ITEM_CNT_W-1:0] rsp_item_count;
   logic                  rsp_last;

   doubly_linked_list_table #(.CAPACITY(CAP)) i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow table
   logic [CODE_W-1:0]  tbl_code [CAP];
   logic [CLASS_W-1:0] tbl_class [CAP];
   logic [PRICE_W-1:0] tbl_price [CAP];
   logic [4:0]         tbl_prev [CAP];
   logic [4:0]         tbl_next [CAP];
   logic [4:0]         head_idx, tail_idx;
   int                 total;

   rsp_item_type expected_rsps [$];
   int  failures = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic bit is_slot(logic [4:0] i);
      return i < CAP;
   endfunction

   function automatic void expect_rsp(logic [STATUS_W-1:0] st, logic [4:0] idx, bit fin);
      rsp_item_type r;
      r = '0;
      r.status = st;
      if (is_slot(idx)) begin
         r.entry_code = tbl_code[idx];
         r.entry_class = tbl_class[idx];
         r.entry_price = tbl_price[idx];
      end
      r.item_count = total[4:0];
      r.last = fin;
      expected_rsps.push_back(r);
   endfunction

   function automatic logic [4:0] find_code(logic [CODE_W-1:0] key);
      logic [4:0] cur;
      cur = head_idx;
      if (key == 0) return NIL;
      for (int s = 0; s < CAP && is_slot(cur); s++) begin
         if (tbl_code[cur] == key) return cur;
         cur = tbl_next[cur];
      end
      return NIL;
   endfunction

   function automatic void link_entry(logic [4:0] n, logic [4:0] p, logic [4:0] q);
      tbl_prev[n] = p;
      tbl_next[n] = q;
      if (is_slot(p)) tbl_next[p] = n; else head_idx = n;
      if (is_slot(q)) tbl_prev[q] = n; else tail_idx = n;
      total++;
   endfunction

   function automatic void unlink_entry(logic [4:0] i);
      logic [4:0] p, q;
      p = tbl_prev[i];
      q = tbl_next[i];
      if (is_slot(q)) tbl_prev[q] = p; else tail_idx = is_slot(p) ? p : NIL;
      if (is_slot(p)) tbl_next[p] = q; else head_idx = is_slot(q) ? q : NIL;
      tbl_prev[i] = NIL;
      tbl_next[i] = NIL;
      if (total > 0) total--;
   endfunction

   function automatic void reset_table();
      for (int i = 0; i < CAP; i++) begin
         tbl_code[i] = '0;
         tbl_class[i] = '0;
         tbl_price[i] = '0;
         tbl_prev[i] = NIL;
         tbl_next[i] = NIL;
      end
      head_idx = NIL;
      tail_idx = NIL;
      total = 0;
   endfunction

   // predict responses of one command and update the shadow table
   function automatic void predict_table_cmd(logic [3:0] cmd, logic [CODE_W-1:0] key,
                                             logic [CODE_W-1:0] code, logic [CLASS_W-1:0] cls,
                                             logic [PRICE_W-1:0] price);
      logic [4:0] at, n, cur, nx;
      int k;
      at = NIL;
      n = NIL;
      if (cmd <= CMD_INSERT_BEFORE) begin
         if (total >= CAP) begin expect_rsp(ST_FULL, NIL, 1); return; end
         if (code == 0) begin expect_rsp(ST_BADCODE, NIL, 1); return; end
         if (cmd >= CMD_INSERT_AFTER) begin
            at = find_code(key);
            if (!is_slot(at)) begin expect_rsp(ST_NOTFOUND, NIL, 1); return; end
         end
         for (int i = CAP - 1; i >= 0; i--)
            if (tbl_code[i] == 0) n = i[4:0];
         if (!is_slot(n)) begin expect_rsp(ST_FULL, NIL, 1); return; end
         tbl_code[n] = code;
         tbl_class[n] = cls;
         tbl_price[n] = price;
         case (cmd)
            CMD_PUSH_FRONT:   link_entry(n, NIL, head_idx);
            CMD_PUSH_BACK:    link_entry(n, tail_idx, NIL);
            CMD_INSERT_AFTER: link_entry(n, at, tbl_next[at]);
            default:          link_entry(n, tbl_prev[at], at);
         endcase
         expect_rsp(ST_OK, NIL, 1);
         return;
      end
      if (cmd > CMD_WALK_BACK) begin expect_rsp(ST_OK, NIL, 1); return; end
      if (total == 0 || !is_slot(head_idx)) begin expect_rsp(ST_EMPTY, NIL, 1); return; end
      if (cmd <= CMD_SEARCH) begin
         case (cmd)
            CMD_POP_FRONT: at = head_idx;
            CMD_POP_BACK:  at = tail_idx;
            default:       at = find_code(key);
         endcase
         if (!is_slot(at)) begin expect_rsp(ST_NOTFOUND, NIL, 1); return; end
         if (cmd == CMD_SEARCH) begin expect_rsp(ST_OK, at, 1); return; end
         // entry reported with the count after removal
         unlink_entry(at);
         expect_rsp(ST_OK, at, 1);
         tbl_code[at] = '0;
         return;
      end
      cur = (cmd == CMD_WALK_FWD) ? head_idx : tail_idx;
      k = 0;
      while (is_slot(cur) && k < MAX_RESULTS && k < CAP) begin
         nx = (cmd == CMD_WALK_FWD) ? tbl_next[cur] : tbl_prev[cur];
         expect_rsp(ST_OK, cur, !is_slot(nx) || k + 1 >= MAX_RESULTS || k + 1 >= CAP);
         k++;
         cur = nx;
      end
      if (k == 0) expect_rsp(ST_EMPTY, NIL, 1);
   endfunction

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item status=%0d code=%0d", $time, rsp_status,
                     rsp_entry_code_out);
            failures++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_status !== exp_r.status || rsp_entry_code_out !== exp_r.entry_code ||
                rsp_entry_class_out !== exp_r.entry_class ||
                rsp_entry_price_out !== exp_r.entry_price ||
                rsp_item_count !== exp_r.item_count || rsp_last !== exp_r.last) begin
               $display("%0t: mismatch expected st=%0d code=%0d cls=%0d price=%0d cnt=%0d last=%0d",
                        $time, exp_r.status, exp_r.entry_code, exp_r.entry_class,
                        exp_r.entry_price, exp_r.item_count, exp_r.last);
               $display("%0t:          actual   st=%0d code=%0d cls=%0d price=%0d cnt=%0d last=%0d",
                        $time, rsp_status, rsp_entry_code_out, rsp_entry_class_out,
                        rsp_entry_price_out, rsp_item_count, rsp_last);
               failures++;
            end
         end
      end
   end

   // receiver stalls, changed at the falling edge
   always @(negedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);

   // push stays high after an accept until the next falling edge decides
   task automatic send_cmd(logic [3:0] cmd, logic [CODE_W-1:0] key, logic [CODE_W-1:0] code,
                           logic [CLASS_W-1:0] cls, logic [PRICE_W-1:0] price);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_ref_code <= key;
      req_new_code <= code;
      req_new_class <= cls;
      req_new_price <= price;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_table_cmd(cmd, key, code, cls, price);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   // directed rows; chk marks rows whose single result is typed in
   typedef struct {
      logic [3:0] cmd;
      logic [CODE_W-1:0] key, code;
      logic [CLASS_W-1:0] cls;
      logic [PRICE_W-1:0] price;
      bit chk;
      logic [STATUS_W-1:0] st;
      logic [4:0] cnt;
   } dir_row;

   localparam logic [CODE_W-1:0] CMAX = '1;
   localparam logic [PRICE_W-1:0] PMAX = '1;

   dir_row rows [] = '{
      '{CMD_POP_FRONT,     0,    0,    0,    0,    1, ST_EMPTY,    0},
      '{CMD_WALK_BACK,     0,    0,    0,    0,    1, ST_EMPTY,    0},
      '{CMD_INSERT_AFTER,  5,    9,    1,    1,    1, ST_NOTFOUND, 0},
      '{CMD_PUSH_BACK,     0,    0,    3,    3,    1, ST_BADCODE,  0},
      '{CMD_PUSH_BACK,     0,    CMAX, 8'hFF, PMAX, 1, ST_OK,     1},
      '{CMD_PUSH_FRONT,    0,    1,    0,    0,    1, ST_OK,       2},
      '{CMD_INSERT_AFTER,  1,    7,    7,    700,  1, ST_OK,       3},
      '{CMD_INSERT_BEFORE, CMAX, 7,    8,    800,  1, ST_OK,       4},
      '{CMD_INSERT_BEFORE, 3,    4,    4,    4,    1, ST_NOTFOUND, 4},
      '{CMD_SEARCH,        0,    0,    0,    0,    1, ST_NOTFOUND, 4},
      '{CMD_SEARCH,        7,    0,    0,    0,    0, 0,           0},
      '{CMD_WALK_FWD,      0,    0,    0,    0,    0, 0,           0},
      '{CMD_WALK_BACK,     0,    0,    0,    0,    0, 0,           0},
      '{CMD_REMOVE_KEY,    7,    0,    0,    0,    0, 0,           0},
      '{CMD_POP_BACK,      0,    0,    0,    0,    0, 0,           0},
      '{4'd12,             0,    0,    0,    0,    1, ST_OK,       2},
      '{4'd15,             CMAX, CMAX, 8'hFF, PMAX, 1, ST_OK,     2},
      '{CMD_POP_FRONT,     0,    0,    0,    0,    0, 0,           0},
      '{CMD_REMOVE_KEY,    2,    0,    0,    0,    1, ST_NOTFOUND, 1}
   };

   function automatic logic [CODE_W-1:0] pick_key();
      logic [4:0] cur;
      int hops;
      // mostly a code that is in the chain
      if (total == 0 || $urandom_range(9) < 2) return CODE_W'($urandom_range(7));
      cur = head_idx;
      hops = $urandom_range(total - 1);
      for (int s = 0; s < hops && is_slot(tbl_next[cur]); s++) cur = tbl_next[cur];
      return tbl_code[cur];
   endfunction

   task automatic random_cmd();
      logic [3:0] cmd;
      logic [CODE_W-1:0] code;
      int r;
      r = $urandom_range(99);
      // fill-biased when light, drain-biased when near full
      if (r < 3) cmd = 4'(10 + $urandom_range(5));
      else if (r < 55 - (total > 12 ? 25 : 0)) cmd = 4'($urandom_range(3));
      else cmd = 4'(4 + $urandom_range(5));
      case ($urandom_range(9))
         0:       code = '0;
         1:       code = CODE_W'($urandom);
         2:       code = CMAX;
         default: code = CODE_W'($urandom_range(12));
      endcase
      send_cmd(cmd, pick_key(), code, CLASS_W'($urandom), PRICE_W'($urandom));
   endtask

   initial begin
      reset_table();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].chk) begin
            rsp_item_type r;
            r = '0;
            r.status = rows[i].st;
            r.item_count = rows[i].cnt;
            r.last = 1'b1;
            send_cmd(rows[i].cmd, rows[i].key, rows[i].code, rows[i].cls, rows[i].price);
            // swap the predictor's result for the typed-in one
            void'(expected_rsps.pop_back());
            expected_rsps.push_back(r);
         end else
            send_cmd(rows[i].cmd, rows[i].key, rows[i].code, rows[i].cls, rows[i].price);
      end

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 73 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 73 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) random_cmd();
         // hold the sender until the table is quiet
         if (ph == 1) drain();
      end

      drain();
      repeat (100) @(negedge clock);
      if (failures == 0)
         $display("doubly_linked_list_table regression: pass");
      else
         $display("doubly_linked_list_table regression: fail");
      $finish;
   end

   initial begin
      #6000000;
      $display("doubly_linked_list_table regression: fail");
      $finish;
   end

endmodule
